FILE: rtl/ssmc_pkg.sv
// ----------------------------------------------------------------------------
// ssmc_pkg
// Shared types and constants for the subarray sum match counter.
// ----------------------------------------------------------------------------
package ssmc_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int SLOT_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = SLOT_W + 1;

    localparam logic [63:0] MIX_ADD = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_M1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_M2 = 64'h94d049bb133111eb;

    localparam logic [47:0] COUNT_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] TALLY_MAX = 32'hFFFF_FFFF;

    localparam logic [0:0] REG_TARGET = 1'b0;
    localparam logic [0:0] REG_SEED = 1'b1;

    typedef struct packed {
        logic signed [31:0] sample_value;
        logic               start_flag;
    } t_in_item;

    typedef struct packed {
        logic [47:0] match_total;
        logic        table_overflow;
    } t_out_item;

    typedef struct packed {
        logic        valid;
        logic [63:0] key;
        logic [31:0] tally;
    } t_slot;

endpackage

FILE: rtl/ssmc_mul32.sv
// ----------------------------------------------------------------------------
// ssmc_mul32
// One 32x32 unsigned partial product with a registered result.
// ----------------------------------------------------------------------------
module ssmc_mul32 (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);

    always_ff @(posedge i_clk) begin
        o_p <= {32'd0, i_a} * {32'd0, i_b};
    end

endmodule

FILE: rtl/ssmc_hash.sv
// ----------------------------------------------------------------------------
// ssmc_hash
// Multicycle splitmix64 unit; each 64-bit product uses three partial
// products, one per cycle, on a shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module ssmc_hash (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [63:0]                i_key,
    output logic                       o_done,
    output logic [ssmc_pkg::SLOT_W-1:0] o_slot
);

    localparam logic [3:0] H_IDLE = 4'd0;
    localparam logic [3:0] H_A1 = 4'd1;
    localparam logic [3:0] H_A2 = 4'd2;
    localparam logic [3:0] H_A3 = 4'd3;
    localparam logic [3:0] H_A4 = 4'd4;
    localparam logic [3:0] H_B1 = 4'd5;
    localparam logic [3:0] H_B2 = 4'd6;
    localparam logic [3:0] H_B3 = 4'd7;
    localparam logic [3:0] H_B4 = 4'd8;

    logic [3:0]  r_st;
    logic [63:0] r_z;
    logic [63:0] r_acc;
    logic [31:0] w_a;
    logic [31:0] w_b;
    logic [63:0] w_p;
    logic [63:0] w_fin;
    logic [63:0] w_m;

    assign w_m = (r_st >= H_B1) ? ssmc_pkg::MIX_M2 : ssmc_pkg::MIX_M1;

    always_comb begin
        w_a = r_z[31:0];
        w_b = w_m[31:0];
        unique case (r_st)
            H_A2, H_B2: begin
                w_a = r_z[31:0];
                w_b = w_m[63:32];
            end
            H_A3, H_B3: begin
                w_a = r_z[63:32];
                w_b = w_m[31:0];
            end
            default: begin
                w_a = r_z[31:0];
                w_b = w_m[31:0];
            end
        endcase
    end

    ssmc_mul32 u_mul (
        .i_clk (i_clk),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_p   (w_p)
    );

    assign w_fin = r_acc + {w_p[31:0], 32'd0};
    assign o_slot = r_z[ssmc_pkg::SLOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= H_IDLE;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_st)
                H_IDLE: begin
                    if (i_start) begin
                        r_z <= (i_key + ssmc_pkg::MIX_ADD) ^
                            ((i_key + ssmc_pkg::MIX_ADD) >> 30);
                        r_st <= H_A1;
                    end
                end
                H_A1: r_st <= H_A2;
                H_A2: begin
                    r_acc <= w_p;
                    r_st <= H_A3;
                end
                H_A3: begin
                    r_acc <= r_acc + {w_p[31:0], 32'd0};
                    r_st <= H_A4;
                end
                H_A4: begin
                    r_z <= w_fin ^ (w_fin >> 27);
                    r_st <= H_B1;
                end
                H_B1: r_st <= H_B2;
                H_B2: begin
                    r_acc <= w_p;
                    r_st <= H_B3;
                end
                H_B3: begin
                    r_acc <= r_acc + {w_p[31:0], 32'd0};
                    r_st <= H_B4;
                end
                H_B4: begin
                    r_z <= w_fin ^ (w_fin >> 31);
                    o_done <= 1'b1;
                    r_st <= H_IDLE;
                end
                default: r_st <= H_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> r_st == H_IDLE) else $error("hash done outside idle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == H_B4) |=> o_done) else $error("hash done missing");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != H_IDLE) |=> $past(r_st) != r_st) else $error("hash stalled");

endmodule

FILE: rtl/subarray_sum_match_counter_unit.sv
// ----------------------------------------------------------------------------
// subarray_sum_match_counter_unit
// Counts contiguous subarrays of a sample stream whose sum equals a target.
// ----------------------------------------------------------------------------
// Usage: an input transaction is taken when i_start is high and o_busy is
// low. Each transaction yields exactly one result on o_result, marked by
// o_result_valid for one cycle; the receiver cannot stall.
// Per transaction the prefix is advanced (restarted on start_flag), then two
// hashes are computed on a shared multicycle splitmix64 unit, and the table
// memory is probed with linear probing, each probed slot being read and
// then compared. The result strobe follows the second probe; o_busy drops
// in the strobe cycle, so the next transaction can be taken at the edge
// that ends it.
// After reset, and whenever a transaction carries start_flag, a clearing
// pass writes all TABLE_ENTRIES table entries (one per cycle) while o_busy
// stays high. The APB port writes target_sum (address 0) and hash_seed
// (address 8); it is always ready.
// ----------------------------------------------------------------------------
module subarray_sum_match_counter_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  ssmc_pkg::t_in_item   i_item,
    output logic                 o_busy,
    output logic                 o_result_valid,
    output ssmc_pkg::t_out_item  o_result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [63:0]          pwdata,
    output logic [63:0]          prdata,
    output logic                 pready
);

    localparam int SW = ssmc_pkg::SLOT_W;
    localparam int CW = ssmc_pkg::CNT_W;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_H1 = 4'd2;
    localparam logic [3:0] S_H1W = 4'd3;
    localparam logic [3:0] S_P1R = 4'd4;
    localparam logic [3:0] S_P1C = 4'd5;
    localparam logic [3:0] S_H2 = 4'd6;
    localparam logic [3:0] S_H2W = 4'd7;
    localparam logic [3:0] S_P2R = 4'd8;
    localparam logic [3:0] S_P2C = 4'd9;
    localparam logic [3:0] S_OUT = 4'd10;

    logic [63:0] r_target;
    logic [63:0] r_seed;
    logic [3:0]  r_st;
    logic [63:0] r_prefix;
    logic [47:0] r_total;
    logic        r_ovf;
    logic [SW-1:0] r_pos;
    logic [CW-1:0] r_cnt;
    logic        r_clr_pend;

    ssmc_pkg::t_slot r_mem [ssmc_pkg::TABLE_ENTRIES];
    ssmc_pkg::t_slot r_rd;
    logic        mem_we;
    ssmc_pkg::t_slot mem_wd;

    logic        h_start;
    logic [63:0] h_key;
    logic        h_done;
    logic [SW-1:0] h_slot;
    logic [63:0] w_diff;
    logic [63:0] w_sample;
    logic        w_wr;
    logic [47:0] w_room;

    assign pready = 1'b1;
    assign w_wr = psel && penable && pwrite;
    assign prdata = (paddr[3] == ssmc_pkg::REG_SEED) ? r_seed : r_target;
    assign w_diff = r_prefix - r_target;
    assign w_sample = {{32{i_item.sample_value[31]}}, i_item.sample_value};
    assign w_room = ssmc_pkg::COUNT_MAX - r_total;
    assign o_busy = (r_st != S_IDLE);
    assign h_start = (r_st == S_H1) || (r_st == S_H2);
    assign h_key = ((r_st == S_H1) ? w_diff : r_prefix) + r_seed;

    ssmc_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (h_start),
        .i_key   (h_key),
        .o_done  (h_done),
        .o_slot  (h_slot)
    );

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_pos] <= mem_wd;
        end
        r_rd <= r_mem[r_pos];
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wd = r_rd;
        if (r_st == S_CLEAR) begin
            mem_we = 1'b1;
            mem_wd = '0;
        end else if (r_st == S_P2C) begin
            if (!r_rd.valid) begin
                mem_we = 1'b1;
                mem_wd.valid = 1'b1;
                mem_wd.key = r_prefix;
                mem_wd.tally = 32'd1;
            end else if (r_rd.key == r_prefix) begin
                mem_we = 1'b1;
                mem_wd.tally = (r_rd.tally == ssmc_pkg::TALLY_MAX) ?
                    r_rd.tally : r_rd.tally + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
            r_seed <= '0;
            r_st <= S_CLEAR;
            r_pos <= '0;
            r_prefix <= '0;
            r_total <= '0;
            r_ovf <= 1'b0;
            r_clr_pend <= 1'b0;
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= 1'b0;
            if (w_wr) begin
                if (paddr[3] == ssmc_pkg::REG_SEED) begin
                    r_seed <= pwdata;
                end else begin
                    r_target <= pwdata;
                end
            end
            unique case (r_st)
                S_CLEAR: begin
                    r_pos <= r_pos + 1'b1;
                    if (r_pos == SW'(ssmc_pkg::TABLE_ENTRIES - 1)) begin
                        r_st <= r_clr_pend ? S_H1 : S_IDLE;
                        r_clr_pend <= 1'b0;
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        if (i_item.start_flag) begin
                            r_prefix <= w_sample;
                            r_total <= '0;
                            r_ovf <= 1'b0;
                            r_clr_pend <= 1'b1;
                            r_pos <= '0;
                            r_st <= S_CLEAR;
                        end else begin
                            r_prefix <= r_prefix + w_sample;
                            r_st <= S_H1;
                        end
                    end
                end
                S_H1: begin
                    if (w_diff == 64'd0 && r_total != ssmc_pkg::COUNT_MAX) begin
                        r_total <= r_total + 48'd1;
                    end
                    r_st <= S_H1W;
                end
                S_H1W: begin
                    if (h_done) begin
                        r_pos <= h_slot;
                        r_cnt <= '0;
                        r_st <= S_P1R;
                    end
                end
                S_P1R: r_st <= S_P1C;
                S_P1C: begin
                    if (!r_rd.valid || r_rd.key == w_diff ||
                        r_cnt == CW'(ssmc_pkg::TABLE_ENTRIES - 1)) begin
                        if (r_rd.valid && r_rd.key == w_diff) begin
                            r_total <= ({16'd0, r_rd.tally} >= w_room) ?
                                ssmc_pkg::COUNT_MAX : r_total + {16'd0, r_rd.tally};
                        end
                        r_st <= S_H2;
                    end else begin
                        r_pos <= r_pos + 1'b1;
                        r_cnt <= r_cnt + 1'b1;
                        r_st <= S_P1R;
                    end
                end
                S_H2: r_st <= S_H2W;
                S_H2W: begin
                    if (h_done) begin
                        r_pos <= h_slot;
                        r_cnt <= '0;
                        r_st <= S_P2R;
                    end
                end
                S_P2R: r_st <= S_P2C;
                S_P2C: begin
                    if (!r_rd.valid || r_rd.key == r_prefix) begin
                        r_st <= S_OUT;
                    end else if (r_cnt == CW'(ssmc_pkg::TABLE_ENTRIES - 1)) begin
                        r_ovf <= 1'b1;
                        r_st <= S_OUT;
                    end else begin
                        r_pos <= r_pos + 1'b1;
                        r_cnt <= r_cnt + 1'b1;
                        r_st <= S_P2R;
                    end
                end
                S_OUT: begin
                    o_result_valid <= 1'b1;
                    o_result.match_total <= r_total;
                    o_result.table_overflow <= r_ovf;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_st) == S_OUT) else $error("stray result");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_OUT) |=> o_result_valid) else $error("result lost");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_st == S_P2C || r_st == S_CLEAR))
        else $error("table write outside update");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("busy not raised");

endmodule
